@@ sv/swec_pkg.sv @@
// ----------------------------------------------------------------------------
// swec_pkg
// shared types and constants for the sliding window event counter
// ----------------------------------------------------------------------------
package swec_pkg;

    localparam int TIME_W  = 31;
    localparam int COUNT_W = 11;

    typedef logic [TIME_W-1:0] t_time;

    // window length after reset, in timestamp units
    localparam t_time WINDOW_RESET = 31'd3000;

    // per cell control from the sequencer
    typedef struct packed {
        logic shift;  // take the neighbor's entry (pop at the head)
        logic load;   // this cell is the tail slot for the new timestamp
    } t_cell_ctl;

endpackage

@@ sv/swec_cell.sv @@
// ----------------------------------------------------------------------------
// swec_cell
// one entry of the timestamp queue, shifts toward the head on a pop
// ----------------------------------------------------------------------------
module swec_cell
    import swec_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_time     i_load_time,
    input  t_time     i_next_time,
    output t_time     o_time
);

    t_time r_time;

    // payload only, no reset: an entry is read only after it was written
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_time <= i_load_time;
        end else if (i_ctl.shift) begin
            r_time <= i_next_time;
        end
    end

    assign o_time = r_time;

endmodule

@@ sv/swec_age_cmp.sv @@
// ----------------------------------------------------------------------------
// swec_age_cmp
// decides whether the head entry has aged out of the window
// ----------------------------------------------------------------------------
module swec_age_cmp
    import swec_pkg::*;
(
    input  t_time i_event_time,
    input  t_time i_head_time,
    input  t_time i_window,
    output logic  o_expired
);

    logic [TIME_W:0] w_diff;

    // borrow out means a negative age, which never exceeds the window
    assign w_diff    = {1'b0, i_event_time} - {1'b0, i_head_time};
    assign o_expired = !w_diff[TIME_W] && (w_diff[TIME_W-1:0] > i_window);

endmodule

@@ sv/sliding_window_event_counter_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_event_counter_unit
// counts the events whose timestamps lie inside a sliding time window
// ----------------------------------------------------------------------------
// Each input beat carries one timestamp. It is appended at the tail of a
// DEPTH-entry queue built as a row of cells (dropped and flagged when the
// queue is full), then entries leave at the head while the new timestamp
// minus the head timestamp is above the window length. The output beat
// gives the number of held events and the drop flag. The accept does the
// push, then the sequencer, in its evict state, either pops one entry (the
// whole row shifts one cell toward the head) or, once it finds the head
// inside the window and the output register is free, finishes. Amortized
// over a stream, an item evicts about one entry. A result sits in an output
// register, so the next item is taken while it waits; only when that
// register is still full does the finished item hold the input side. The
// window length register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_event_counter_unit
    import swec_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // window length register
    input  logic                i_cfg_wr_en,
    input  logic [TIME_W-1:0]   i_cfg_wr_data,

    // timestamp beats
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [TIME_W-1:0]   i_event_time,

    // count beats
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [COUNT_W-1:0]  o_recent_count,
    output logic                o_push_dropped
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic S_IDLE  = 1'b0;
    localparam logic S_EVICT = 1'b1;

    logic               r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    t_time              r_window;
    t_time              r_time;       // timestamp of the item at work
    logic               r_drop;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_drop;

    logic               w_accept;
    logic               w_full;
    logic               w_push;
    logic               w_expired;
    logic               w_pop;
    logic               w_done;
    logic               w_out_free;

    t_time              w_cell_q [DEPTH];
    t_cell_ctl          w_ctl    [DEPTH];

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_push     = w_accept && !w_full;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // head cell against the item's timestamp
    swec_age_cmp u_age_cmp (
        .i_event_time (r_time),
        .i_head_time  (w_cell_q[0]),
        .i_window     (r_window),
        .o_expired    (w_expired)
    );

    // pop while something is held and the head is too old
    assign w_pop  = (r_state == S_EVICT) && (r_count != '0) && w_expired;
    assign w_done = (r_state == S_EVICT) && !((r_count != '0) && w_expired) && w_out_free;

    // row of queue cells, cell 0 is the head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_time w_next;

        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_q[g+1];
        end

        assign w_ctl[g].shift = w_pop;
        assign w_ctl[g].load  = w_push && (r_count == CNT_W'(g));

        swec_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_load_time (i_event_time),
            .i_next_time (w_next),
            .o_time      (w_cell_q[g])
        );
    end

    // sequencer and fill count
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVICT;
                    if (!w_full) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            S_EVICT: begin
                if (w_pop) begin
                    n_count = r_count - CNT_W'(1);
                end else if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_window <= WINDOW_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
        end
    end

    // item timestamp and drop flag, captured at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time <= i_event_time;
            r_drop <= w_full;
        end
    end

    // output register, loaded only when the slot is free so a stalled beat holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_count <= COUNT_W'(r_count);
            r_out_drop  <= r_drop;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_recent_count = r_out_count;
    assign o_push_dropped = r_out_drop;

endmodule

@@ sv/swec_checker.sv @@
// ----------------------------------------------------------------------------
// swec_checker
// port level checks for the sliding window event counter
// ----------------------------------------------------------------------------
module swec_checker
    import swec_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [COUNT_W-1:0] o_recent_count,
    input logic               o_push_dropped
);

    // a stalled output beat stays valid
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat withdrawn while stalled");

    // a stalled output beat keeps its payload
    a_out_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_recent_count) && $stable(o_push_dropped))
        else $error("output payload changed while stalled");

    // the input stalls right after an accept, while the item is at work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after an accept");

    // a stored timestamp is never evicted by its own item
    a_stored_survives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_push_dropped |-> (DEPTH >= 2048) || (o_recent_count != '0))
        else $error("zero count reported for a stored timestamp");

endmodule

bind sliding_window_event_counter_unit swec_checker #(
    .DEPTH (DEPTH)
) u_swec_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_recent_count (o_recent_count),
    .o_push_dropped (o_push_dropped)
);

@@ verif/sliding_window_event_counter_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_event_counter_unit_test
// self-checking bench for the sliding window event counter
// ----------------------------------------------------------------------------
// Timestamps are fed through the valid/stall input port with random gaps while
// the count port stalls at random, including two long hold-offs that back the
// block up into its input. A behavioral copy of the timestamp queue predicts
// the held count and drop flag for every accepted timestamp, and each count
// beat is compared against the oldest prediction. The run walks through the
// reset window, a zero window, random windows, the widest window with a long
// run of held stamps, then halved, and a narrow window that empties the queue.
// ----------------------------------------------------------------------------
module sliding_window_event_counter_unit_test;
    import swec_pkg::*;

    localparam int DEPTH = 1024;

    // cycles to wait for the last counts, and the padding after them
    localparam int DRAIN_LIMIT = 4 * DEPTH + 1000;
    localparam int DRAIN_PAD   = DEPTH + 8;

    // long receiver hold-off, in cycles, and the count beats where it starts
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT_A   = 30;
    localparam int HOLD_AT_B   = 300;

    // largest timestamp and the largest step of well-formed streams
    localparam t_time TIME_MAX  = {TIME_W{1'b1}};
    localparam int    STEP_CEIL = 1 << 18;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [TIME_W-1:0]  i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [TIME_W-1:0]  i_event_time;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [COUNT_W-1:0] o_recent_count;
    logic               o_push_dropped;

    // one expected count beat
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } t_count_beat;

    // --------------------------------------------------------------------
    // behavioral timestamp queue and the counts it predicts
    // --------------------------------------------------------------------
    class window_tally;
        t_time       stamps [DEPTH];
        int unsigned oldest;
        int unsigned held;
        t_time       window_len;
        t_count_beat due [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned drops;
        int unsigned peak;

        function new();
            oldest     = 0;
            held       = 0;
            window_len = WINDOW_RESET;
            errors     = 0;
            checked    = 0;
            drops      = 0;
            peak       = 0;
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        // push at the tail unless full, then age entries out at the head;
        // the difference is signed so an out-of-order stamp evicts nothing
        function void take_event(t_time stamp);
            t_count_beat beat;
            beat.dropped = (held >= DEPTH);
            if (!beat.dropped) begin
                stamps[(oldest + held) % DEPTH] = stamp;
                held++;
            end
            while (held > 0 &&
                   longint'(stamp) - longint'(stamps[oldest]) > longint'(window_len)) begin
                oldest = (oldest + 1) % DEPTH;
                held--;
            end
            beat.count = COUNT_W'(held);
            due.push_back(beat);
        endfunction

        function void match_count(logic [COUNT_W-1:0] count, logic dropped);
            t_count_beat want;
            if (due.size() == 0) begin
                $display("%0t: count beat with none outstanding, expected none, actual %0d/%0b",
                         $time, count, dropped);
                errors++;
                return;
            end
            want = due.pop_front();
            checked++;
            if (count !== want.count) begin
                $display("%0t: recent_count expected %0d, actual %0d",
                         $time, want.count, count);
                errors++;
            end
            if (dropped !== want.dropped) begin
                $display("%0t: push_dropped expected %0b, actual %0b",
                         $time, want.dropped, dropped);
                errors++;
            end
            if (want.dropped) drops++;
            if (want.count > peak) peak = want.count;
        endfunction
    endclass

    window_tally tally;
    t_time       now_stamp;
    int unsigned events_sent;
    int unsigned windows_set;
    int unsigned feed_mode;

    sliding_window_event_counter_unit #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_event_time  (i_event_time),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_recent_count(o_recent_count),
        .o_push_dropped(o_push_dropped)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // input side: one timestamp beat, with a random gap in front of it
    // --------------------------------------------------------------------
    task automatic send_event(input t_time stamp);
        int unsigned gap;
        // every 32 beats pick whether this stretch idles at all
        if (events_sent % 32 == 0) feed_mode = $urandom_range(0, 3);
        gap = (feed_mode == 0) ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_event_time <= stamp;
        // beat moves on the rising edge where valid is high and stall is low
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tally.take_event(stamp);
        events_sent++;
    endtask

    // mostly non-decreasing stamps; a share of them out of order or far ahead
    task automatic run_stream(input int n, input int unsigned step_cap,
                              input int unsigned noise_pct);
        t_time stamp;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                if ($urandom_range(0, 1) == 0) begin
                    // older than what came before
                    stamp = now_stamp - t_time'($urandom_range(1, step_cap + 64));
                end else begin
                    // big jump ahead, clears most of the window
                    now_stamp = now_stamp + t_time'($urandom_range(0, 1 << 20));
                    stamp     = now_stamp;
                end
            end else begin
                now_stamp = now_stamp + t_time'($urandom_range(0, step_cap));
                stamp     = now_stamp;
            end
            send_event(stamp);
        end
    endtask

    // window writes only once every outstanding count has come back
    task automatic set_window(input t_time len);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tally.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tally.window_len = len;
        windows_set++;
    endtask

    // --------------------------------------------------------------------
    // output side: random stall before each count beat, two long hold-offs
    // that fill the block up while timestamps keep coming
    // --------------------------------------------------------------------
    initial begin : count_sink
        int unsigned hold;
        int unsigned sink_mode;
        int unsigned beats;
        i_out_stall = 1'b0;
        sink_mode   = 0;
        beats       = 0;
        forever begin
            @(negedge i_clk);
            if (beats % 32 == 0) sink_mode = $urandom_range(0, 3);
            if (beats == HOLD_AT_A || beats == HOLD_AT_B)
                hold = HOLD_CYCLES;
            else
                hold = (sink_mode == 0) ? 0 : $urandom_range(0, 5);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
            tally.match_count(o_recent_count, o_push_dropped);
            beats++;
        end
    end

    // --------------------------------------------------------------------
    // stimulus and end of run
    // --------------------------------------------------------------------
    initial begin : stimulus
        t_time       len;
        t_time       span_base;
        int unsigned cap;
        int unsigned spin;

        tally         = new();
        now_stamp     = '0;
        events_sent   = 0;
        windows_set   = 0;
        feed_mode     = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_event_time  = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, with the window left at its reset length
        send_event(31'd0);
        send_event(31'd0);              // equal stamps both held
        send_event(31'd3000);           // age exactly the window, kept
        send_event(31'd3001);           // one past the window, both zeros leave
        send_event(31'd6001);
        send_event(31'd2000);           // out of order, head is newer
        send_event(31'd9002);           // ages out everything older, stale one too
        send_event(31'h2AAA_AAAA);      // far jump empties the queue
        send_event(31'h2AAA_AAAA);
        now_stamp = 31'h2AAA_AAAA;

        // zero window: only equal stamps stay together
        set_window('0);
        run_stream(30, 1, 10);

        // random windows, steps scaled so a handful of events stay held
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 3))
                0:       len = t_time'($urandom_range(0, 64));
                1:       len = t_time'($urandom_range(65, 5000));
                2:       len = t_time'($urandom);
                default: len = WINDOW_RESET;
            endcase
            set_window(len);
            cap = (len >> 2) + 1;
            if (cap > STEP_CEIL) cap = STEP_CEIL;
            // before the seventh window, move into the upper half of the stamp range
            if (p == 6) begin
                now_stamp = 31'h5555_5555;
                send_event(now_stamp);
            end
            run_stream(40, cap, 10);
        end

        // widest window: nothing ages out, so the queue builds up
        set_window(TIME_MAX);
        span_base = now_stamp;
        run_stream(100, 3, 0);

        // halve the window: a partial eviction of the held run
        set_window((now_stamp - span_base) >> 1);
        send_event(now_stamp);
        run_stream(20, 3, 0);

        // narrow window and the latest possible stamp empty the queue
        set_window(31'd5);
        send_event(TIME_MAX);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        spin = 0;
        while (tally.pending() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (DRAIN_PAD) @(posedge i_clk);
        if (tally.pending() != 0) begin
            $display("%0t: %0d count beats never arrived, expected 0 outstanding",
                     $time, tally.pending());
            tally.errors++;
        end

        $display("ran %0d timestamps under %0d window settings, %0d count beats checked",
                 events_sent, windows_set, tally.checked);
        $display("%0d pushes dropped on a full queue, largest held count %0d",
                 tally.drops, tally.peak);
        if (tally.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #1000000;
        $display("%0t: run did not finish in time", $time);
        $display("status: fail");
        $finish;
    end

endmodule
